### design/tqe_pkg.sv
// Shared types and constants of the time-ordered event queue.
package tqe_pkg;

    localparam int TimeW = 32;
    localparam int IdW   = 4;
    localparam int RankW = 8;
    localparam int CplW  = 16;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_RUN    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_RUN,
        ST_DIV,
        ST_PUT
    } t_state;

    // Classified request handed from front to back.
    typedef struct packed {
        t_op              op;
        logic [IdW-1:0]   id;
        logic             id_ok;
        logic [TimeW-1:0] t;
        logic [RankW-1:0] rank;
    } t_cmd;

    typedef struct packed {
        logic             kind;
        logic [IdW-1:0]   id;
        logic [TimeW-1:0] line;
        logic [CplW-1:0]  cyl;
        logic             last;
    } t_res;

endpackage

### design/tqe_front.sv
// Front end: request intake, classification and a two-entry request queue.
module tqe_front #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [1:0]                 i_operation,
    input  logic [tqe_pkg::IdW-1:0]    i_event_id,
    input  logic [tqe_pkg::TimeW-1:0]  i_due_time,
    input  logic [tqe_pkg::RankW-1:0]  i_priority_req,
    input  logic [tqe_pkg::TimeW-1:0]  i_until_time,
    output logic                       o_cmd_valid,
    output tqe_pkg::t_cmd              o_cmd,
    input  logic                       i_cmd_take
);

    tqe_pkg::t_cmd w_cmd;
    tqe_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_wr, w_rd;

    always_comb begin
        w_cmd.op    = tqe_pkg::t_op'(i_operation);
        w_cmd.id    = i_event_id;
        w_cmd.id_ok = (int'(i_event_id) < NUM_SLOTS);
        w_cmd.t     = (w_cmd.op == tqe_pkg::OP_RUN) ? i_until_time : i_due_time;
        w_cmd.rank  = i_priority_req;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_q[r_wp] <= w_cmd;
    end

endmodule

### design/tqe_div.sv
// Restoring divider, one quotient bit per cycle: time by cylinders per line.
module tqe_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tqe_pkg::TimeW-1:0]  i_dividend,
    input  logic [tqe_pkg::CplW-1:0]   i_divisor,
    output logic                       o_done,
    output logic [tqe_pkg::TimeW-1:0]  o_quot,
    output logic [tqe_pkg::CplW-1:0]   o_rem
);

    localparam int CntW = $clog2(tqe_pkg::TimeW);

    logic [tqe_pkg::TimeW-1:0] r_q;
    logic [tqe_pkg::CplW-1:0]  r_rem, r_d;
    logic [CntW-1:0]           r_cnt;
    logic                      r_busy, r_done;
    logic [tqe_pkg::CplW:0]    w_sh, w_diff;

    assign w_sh   = {r_rem, r_q[tqe_pkg::TimeW-1]};
    assign w_diff = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(tqe_pkg::TimeW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[tqe_pkg::CplW]) begin
                r_rem <= w_diff[tqe_pkg::CplW-1:0];
                r_q   <= {r_q[tqe_pkg::TimeW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[tqe_pkg::CplW-1:0];
                r_q   <= {r_q[tqe_pkg::TimeW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

### design/tqe_back.sv
// Back end: sorted event list, run sequencer and a two-entry result queue.
module tqe_back #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  tqe_pkg::t_cmd             i_cmd,
    output logic                      o_cmd_take,
    input  logic [tqe_pkg::CplW-1:0]  i_cpl,
    output logic                      o_empty,
    input  logic                      i_pop,
    output tqe_pkg::t_res             o_res
);

    localparam int CW = $clog2(NUM_SLOTS + 1);

    // sorted list: position 0 is the next event due
    logic [tqe_pkg::TimeW-1:0] r_et [NUM_SLOTS];
    logic [tqe_pkg::RankW-1:0] r_er [NUM_SLOTS];
    logic [tqe_pkg::IdW-1:0]   r_ei [NUM_SLOTS];
    logic [tqe_pkg::TimeW-1:0] n_et [NUM_SLOTS];
    logic [tqe_pkg::RankW-1:0] n_er [NUM_SLOTS];
    logic [tqe_pkg::IdW-1:0]   n_ei [NUM_SLOTS];
    logic [CW-1:0]             r_count;

    tqe_pkg::t_state r_state, n_state;
    tqe_pkg::t_cmd   r_cmd;
    logic            r_kind, r_last;
    logic [tqe_pkg::IdW-1:0] r_rid;

    logic                    c_clr, c_drop, c_ins, c_start, c_load, c_push, c_res_ev;
    logic [tqe_pkg::IdW-1:0] c_drop_id;
    logic [tqe_pkg::TimeW-1:0] c_div_t;
    logic                    w_head_due, w_hit;
    logic [NUM_SLOTS-1:0]    w_m, w_pre, w_g;

    logic                      w_done;
    logic [tqe_pkg::TimeW-1:0] w_quot;
    logic [tqe_pkg::CplW-1:0]  w_rem;
    logic [tqe_pkg::CplW-1:0]  w_div;

    tqe_pkg::t_res r_of [2];
    logic          r_of_wp, r_of_rp;
    logic [1:0]    r_of_cnt;
    logic          w_of_rd;

    assign w_div      = (i_cpl == '0) ? tqe_pkg::CplW'(1) : i_cpl;
    assign w_head_due = (r_count != '0) && (r_et[0] <= r_cmd.t);

    tqe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (c_start),
        .i_dividend (c_div_t),
        .i_divisor  (w_div),
        .o_done     (w_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        c_clr     = 1'b0;
        c_drop    = 1'b0;
        c_ins     = 1'b0;
        c_start   = 1'b0;
        c_load    = 1'b0;
        c_push    = 1'b0;
        c_res_ev  = 1'b0;
        c_drop_id = i_cmd.id;
        c_div_t   = r_cmd.t;
        o_cmd_take = 1'b0;
        unique case (r_state)
            tqe_pkg::ST_IDLE: begin
                o_cmd_take = 1'b1;
                if (i_cmd_valid) begin
                    c_load = 1'b1;
                    unique case (i_cmd.op)
                        tqe_pkg::OP_CLEAR:  c_clr = 1'b1;
                        tqe_pkg::OP_INSERT: begin
                            if (i_cmd.id_ok) begin
                                c_drop  = 1'b1;   // reinsert drops the old entry first
                                n_state = tqe_pkg::ST_ADD;
                            end
                        end
                        tqe_pkg::OP_REMOVE: c_drop = i_cmd.id_ok;
                        tqe_pkg::OP_RUN:    n_state = tqe_pkg::ST_RUN;
                        default: ;
                    endcase
                end
            end
            tqe_pkg::ST_ADD: begin
                c_ins   = (r_count < CW'(NUM_SLOTS));
                n_state = tqe_pkg::ST_IDLE;
            end
            tqe_pkg::ST_RUN: begin
                c_start = 1'b1;
                if (w_head_due) begin
                    c_drop    = 1'b1;
                    c_drop_id = r_ei[0];
                    c_div_t   = r_et[0];
                    c_res_ev  = 1'b1;
                end
                n_state = tqe_pkg::ST_DIV;
            end
            tqe_pkg::ST_DIV: begin
                if (w_done) n_state = tqe_pkg::ST_PUT;
            end
            tqe_pkg::ST_PUT: begin
                if (r_of_cnt != 2'd2) begin
                    c_push  = 1'b1;
                    n_state = r_last ? tqe_pkg::ST_IDLE : tqe_pkg::ST_RUN;
                end
            end
            default: n_state = tqe_pkg::ST_IDLE;
        endcase
    end

    // list next value: drop closes the gap, insert opens one
    always_comb begin
        for (int p = 0; p < NUM_SLOTS; p++) begin
            w_m[p] = (CW'(p) < r_count) && (r_ei[p] == c_drop_id);
            w_g[p] = (CW'(p) >= r_count) || (r_cmd.t < r_et[p]) ||
                     ((r_cmd.t == r_et[p]) && (r_cmd.rank > r_er[p]));
        end
        w_pre[0] = w_m[0];
        for (int p = 1; p < NUM_SLOTS; p++) w_pre[p] = w_pre[p-1] | w_m[p];
        w_hit = w_pre[NUM_SLOTS-1];
        for (int p = 0; p < NUM_SLOTS; p++) begin
            n_et[p] = r_et[p];
            n_er[p] = r_er[p];
            n_ei[p] = r_ei[p];
            if (c_ins) begin
                if (w_g[p] && (p == 0 || !w_g[(p > 0) ? p - 1 : 0])) begin
                    n_et[p] = r_cmd.t;
                    n_er[p] = r_cmd.rank;
                    n_ei[p] = r_cmd.id;
                end else if (w_g[p] && p > 0) begin
                    n_et[p] = r_et[(p > 0) ? p - 1 : 0];
                    n_er[p] = r_er[(p > 0) ? p - 1 : 0];
                    n_ei[p] = r_ei[(p > 0) ? p - 1 : 0];
                end
            end else if (w_pre[p] && p < NUM_SLOTS - 1) begin
                n_et[p] = r_et[(p < NUM_SLOTS - 1) ? p + 1 : p];
                n_er[p] = r_er[(p < NUM_SLOTS - 1) ? p + 1 : p];
                n_ei[p] = r_ei[(p < NUM_SLOTS - 1) ? p + 1 : p];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ins || c_drop) begin
            r_et <= n_et;
            r_er <= n_er;
            r_ei <= n_ei;
        end
        if (c_load) r_cmd <= i_cmd;
        if (c_start) begin
            r_kind <= !c_res_ev;
            r_rid  <= c_res_ev ? c_drop_id : '0;
            r_last <= !c_res_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tqe_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (c_clr) begin
                r_count <= '0;
            end else if (c_ins) begin
                r_count <= r_count + 1'b1;
            end else if (c_drop && w_hit) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // result queue
    assign w_of_rd = i_pop && !o_empty;
    assign o_empty = (r_of_cnt == 2'd0);
    assign o_res   = r_of[r_of_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_of_wp  <= 1'b0;
            r_of_rp  <= 1'b0;
            r_of_cnt <= 2'd0;
        end else begin
            if (c_push)  r_of_wp <= !r_of_wp;
            if (w_of_rd) r_of_rp <= !r_of_rp;
            r_of_cnt <= r_of_cnt + {1'b0, c_push} - {1'b0, w_of_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_of[r_of_wp].kind <= r_kind;
            r_of[r_of_wp].id   <= r_rid;
            r_of[r_of_wp].line <= w_quot;
            r_of[r_of_wp].cyl  <= w_rem;
            r_of[r_of_wp].last <= r_last;
        end
    end

endmodule

### design/time_ordered_event_queue.sv
// Top level of the time-ordered event queue: config register, front and back ends.
//
//  channel   direction  handshake                 payload
//  request   in         push / full               operation, event_id, due_time,
//                                                 priority_req, until_time
//  result    out        empty / pop               kind, fired_id, line, cylinder, last
//  config    in         cfg_valid / cfg_ready     cfg_data (cylinders per line)
//
// Clear and remove complete in the idle state of the back end; insert also goes
// through the add state. A run gives a result per fired event and a closing one,
// each waiting on the bit-serial divider that splits its time into line and cylinder.
// Reset is synchronous, active low; it empties the list and both queues.
// The front queue holds two requests while the back end works; the result
// queue holds two results, and a full result queue stalls the run sequencer.
module time_ordered_event_queue #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request side
    input  logic                       push,
    output logic                       full,
    input  logic [1:0]                 i_operation,
    input  logic [tqe_pkg::IdW-1:0]    i_event_id,
    input  logic [tqe_pkg::TimeW-1:0]  i_due_time,
    input  logic [tqe_pkg::RankW-1:0]  i_priority_req,
    input  logic [tqe_pkg::TimeW-1:0]  i_until_time,
    // result side
    output logic                       empty,
    input  logic                       pop,
    output logic                       o_kind,
    output logic [tqe_pkg::IdW-1:0]    o_fired_id,
    output logic [tqe_pkg::TimeW-1:0]  o_line,
    output logic [tqe_pkg::CplW-1:0]   o_cylinder,
    output logic                       o_last,
    // config side
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tqe_pkg::CplW-1:0]   i_cfg_data
);

    logic [tqe_pkg::CplW-1:0] r_cpl;   // cylinders per line
    logic                     w_cmd_valid, w_cmd_take;
    tqe_pkg::t_cmd            w_cmd;
    tqe_pkg::t_res            w_res;

    // config writes always land; the user must send them only while the block is quiet: it does not enforce this
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpl <= tqe_pkg::CplW'(454);
        end else if (i_cfg_valid) begin
            r_cpl <= i_cfg_data;
        end
    end

    tqe_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_operation    (i_operation),
        .i_event_id     (i_event_id),
        .i_due_time     (i_due_time),
        .i_priority_req (i_priority_req),
        .i_until_time   (i_until_time),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_cmd_take     (w_cmd_take)
    );

    tqe_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .i_cpl       (r_cpl),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (w_res)
    );

    assign o_kind     = w_res.kind;
    assign o_fired_id = w_res.id;
    assign o_line     = w_res.line;
    assign o_cylinder = w_res.cyl;
    assign o_last     = w_res.last;

`ifndef SYNTHESIS
    // only the serializer request closes a run
    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_kind == o_last))
        else $error("kind and last disagree");

    a_adv_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind) |-> (o_fired_id == '0))
        else $error("serializer result carries an id");

    // remainder must stay below the effective divisor
    a_cyl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && r_cpl != '0) |-> (o_cylinder < r_cpl))
        else $error("cylinder out of range");
`endif

endmodule
